// File: src/scfd_pkg.sv
// Types, command addresses and filter band decode for the control frame decoder.
package scfd_pkg;

    typedef struct packed {
        logic [31:0] seq_number;
        logic [7:0]  slot0_c0;
        logic [7:0]  slot0_c1;
        logic [7:0]  slot0_c2;
        logic [7:0]  slot0_c3;
        logic [7:0]  slot0_c4;
        logic [7:0]  slot1_c0;
        logic [7:0]  slot1_c1;
        logic [7:0]  slot1_c2;
        logic [7:0]  slot1_c3;
        logic [7:0]  slot1_c4;
    } scfd_in_t;

    typedef struct packed {
        logic        seq_error;
        logic        transmit_on;
        logic [1:0]  rate_code;
        logic [3:0]  rx_count;
        logic [6:0]  rx_control_code;
        logic [31:0] rx1_freq;
        logic [31:0] rx2_freq;
        logic [31:0] tx_freq;
        logic [7:0]  tx_drive;
        logic [15:0] filter_word;
        logic        filter_write;
    } scfd_out_t;

    // Command addresses (C0 with bit 0 cleared)
    localparam logic [7:0] ADDR_GENERAL = 8'h00;
    localparam logic [7:0] ADDR_TXFREQ  = 8'h02;
    localparam logic [7:0] ADDR_RX1FREQ = 8'h04;
    localparam logic [7:0] ADDR_RX2FREQ = 8'h06;
    localparam logic [7:0] ADDR_DRIVE   = 8'h12;
    localparam logic [7:0] ADDR_ATTEN   = 8'h14;

    localparam logic [7:0] MANUAL_HP_MASK = 8'h8F;

    // Reset values
    localparam logic [31:0] RX1_FREQ_RST  = 32'd4706000;
    localparam logic [31:0] RX2_FREQ_RST  = 32'd1008000;
    localparam logic [31:0] TX_FREQ_RST   = 32'd3630000;
    localparam logic [3:0]  RX_COUNT_RST  = 4'd2;

    // High-pass band edges
    localparam logic [31:0] HP_EDGE0 = 32'd1416000;
    localparam logic [31:0] HP_EDGE1 = 32'd6500000;
    localparam logic [31:0] HP_EDGE2 = 32'd9500000;
    localparam logic [31:0] HP_EDGE3 = 32'd13000000;
    localparam logic [31:0] HP_EDGE4 = 32'd20000000;

    // Low-pass band edges (frequency at or above the listed value)
    localparam logic [31:0] LP_EDGE0 = 32'd32000001;
    localparam logic [31:0] LP_EDGE1 = 32'd22000001;
    localparam logic [31:0] LP_EDGE2 = 32'd15000001;
    localparam logic [31:0] LP_EDGE3 = 32'd8000001;
    localparam logic [31:0] LP_EDGE4 = 32'd4500001;
    localparam logic [31:0] LP_EDGE5 = 32'd2400001;

    localparam logic [7:0] HP_1K5  = 8'h20;
    localparam logic [7:0] HP_6M5  = 8'h10;
    localparam logic [7:0] HP_9M5  = 8'h08;
    localparam logic [7:0] HP_13M  = 8'h04;
    localparam logic [7:0] HP_20M  = 8'h01;
    localparam logic [7:0] HP_BYP  = 8'h02;

    localparam logic [7:0] LP_6M   = 8'h10;
    localparam logic [7:0] LP_10M  = 8'h20;
    localparam logic [7:0] LP_17M  = 8'h40;
    localparam logic [7:0] LP_30M  = 8'h01;
    localparam logic [7:0] LP_60M  = 8'h02;
    localparam logic [7:0] LP_80M  = 8'h04;
    localparam logic [7:0] LP_160M = 8'h08;

    // Signed compare against a positive edge: bit 31 set means negative
    function automatic logic below(input logic [31:0] f, input logic [31:0] t);
        below = f[31] || (f < t);
    endfunction

    function automatic logic [15:0] auto_filter(input logic [31:0] f);
        logic [7:0] hp;
        logic [7:0] lp;
        if (below(f, HP_EDGE0))      hp = HP_1K5;
        else if (below(f, HP_EDGE1)) hp = HP_6M5;
        else if (below(f, HP_EDGE2)) hp = HP_9M5;
        else if (below(f, HP_EDGE3)) hp = HP_13M;
        else if (below(f, HP_EDGE4)) hp = HP_20M;
        else                         hp = HP_BYP;

        if (!below(f, LP_EDGE0))      lp = LP_6M;
        else if (!below(f, LP_EDGE1)) lp = LP_10M;
        else if (!below(f, LP_EDGE2)) lp = LP_17M;
        else if (!below(f, LP_EDGE3)) lp = LP_30M;
        else if (!below(f, LP_EDGE4)) lp = LP_60M;
        else if (!below(f, LP_EDGE5)) lp = LP_80M;
        else                          lp = LP_160M;
        auto_filter = {hp, lp};
    endfunction

endpackage

// File: src/sdr_control_frame_decoder.sv
// Control frame decoder: packet header in, current receiver/transmit settings out.
//
// s_ channel: one packet header per transfer (sequence number plus the two
// C0..C4 control blocks). m_ channel: one settings record per header, in order.
// cfg channel: single write-only bit, filter board present; always ready and
// meant to be written while no header is in flight.
//
// Data path: an accepted header is held in the input register, then the decode
// and settings update land in the result register, which drives m_valid and m_data.
// Throughput: one header per cycle while m_ready is high; the whole update is
// one pass of shallow logic between the input register and the result register.
//
// Reset (aresetn low, synchronous) empties both registers and loads the
// default settings (2 receivers, default frequencies, filter board absent).
// When m_ready is low the result holds; the input register still takes one
// more header, then s_ready drops until the result is taken.
module sdr_control_frame_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  scfd_pkg::scfd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output scfd_pkg::scfd_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import scfd_pkg::*;

    scfd_in_t    in_reg;
    logic        in_valid_reg;
    scfd_out_t   out_reg, out_next;
    logic        out_valid_reg;
    logic        board_reg;

    logic [31:0] last_seq_reg, last_seq_next;
    logic [4:0]  atten_reg, atten_next;
    logic [4:0]  atten_s0_reg, atten_s0_next;
    logic [4:0]  atten_s1_reg, atten_s1_next;
    logic        dither_reg, dither_next;
    logic        random_reg, random_next;
    logic [3:0]  receivers_reg, receivers_next;
    logic [1:0]  rate_reg, rate_next;
    logic [31:0] rx1_reg, rx1_next;
    logic [31:0] rx2_reg, rx2_next;
    logic [31:0] tx_reg, tx_next;
    logic [7:0]  drive_reg, drive_next;
    logic [15:0] filt_val_reg, filt_val_next;
    logic [15:0] filt_sent_reg, filt_sent_next;
    logic        filt_wr;

    logic        advance;
    logic [7:0]  a0, a1;
    logic [31:0] word0, word1;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign a0    = {in_reg.slot0_c0[7:1], 1'b0};
    assign a1    = {in_reg.slot1_c0[7:1], 1'b0};
    assign word0 = {in_reg.slot0_c1, in_reg.slot0_c2, in_reg.slot0_c3, in_reg.slot0_c4};
    assign word1 = {in_reg.slot1_c1, in_reg.slot1_c2, in_reg.slot1_c3, in_reg.slot1_c4};

    always_comb begin
        last_seq_next  = in_reg.seq_number;
        atten_next     = atten_reg;
        atten_s0_next  = atten_s0_reg;
        atten_s1_next  = atten_s1_reg;
        dither_next    = dither_reg;
        random_next    = random_reg;
        receivers_next = receivers_reg;
        rate_next      = rate_reg;
        rx1_next       = rx1_reg;
        rx2_next       = rx2_reg;
        tx_next        = tx_reg;
        drive_next     = drive_reg;
        filt_val_next  = filt_val_reg;
        filt_sent_next = filt_sent_reg;
        filt_wr        = 1'b0;

        if (a0 == ADDR_ATTEN) begin
            atten_next    = in_reg.slot0_c4[4:0];
            atten_s0_next = in_reg.slot0_c4[4:0];
        end
        if (a1 == ADDR_ATTEN) begin
            atten_next    = in_reg.slot1_c4[4:0];
            atten_s1_next = in_reg.slot1_c4[4:0];
        end
        // a changed slot latch overrides; slot 1 has the last word
        if (atten_s0_next != atten_s0_reg) atten_next = atten_s0_next;
        if (atten_s1_next != atten_s1_reg) atten_next = atten_s1_next;

        if (a0 == ADDR_GENERAL) begin
            receivers_next = {1'b0, in_reg.slot0_c4[5:3]} + 4'd1;
            rate_next      = in_reg.slot0_c1[1:0];
            dither_next    = in_reg.slot0_c3[3];
            random_next    = in_reg.slot0_c3[4];
        end
        if (a1 == ADDR_GENERAL) begin
            receivers_next = {1'b0, in_reg.slot1_c4[5:3]} + 4'd1;
            dither_next    = in_reg.slot1_c3[3];
            random_next    = in_reg.slot1_c3[4];
        end

        if (a0 == ADDR_TXFREQ)  tx_next  = word0;
        if (a1 == ADDR_TXFREQ)  tx_next  = word1;
        if (a0 == ADDR_RX1FREQ) rx1_next = word0;
        if (a1 == ADDR_RX1FREQ) rx1_next = word1;
        if (a0 == ADDR_RX2FREQ) rx2_next = word0;
        if (a1 == ADDR_RX2FREQ) rx2_next = word1;

        if (a1 == ADDR_DRIVE) drive_next = in_reg.slot1_c1;

        if (board_reg && a1 == ADDR_DRIVE) begin
            if (in_reg.slot1_c2[6]) begin
                filt_val_next = {in_reg.slot1_c3 & MANUAL_HP_MASK, in_reg.slot1_c4};
            end else begin
                filt_val_next = auto_filter(rx1_next);
            end
        end

        if (board_reg && filt_sent_reg != filt_val_next) begin
            filt_sent_next = filt_val_next;
            filt_wr        = 1'b1;
        end

        out_next.seq_error       = in_reg.seq_number != (last_seq_reg + 32'd1);
        out_next.transmit_on     = in_reg.slot0_c0[0];
        out_next.rate_code       = rate_next;
        out_next.rx_count        = receivers_next;
        out_next.rx_control_code = {random_next, dither_next, atten_next};
        out_next.rx1_freq        = rx1_next;
        out_next.rx2_freq        = rx2_next;
        out_next.tx_freq         = tx_next;
        out_next.tx_drive        = drive_next;
        out_next.filter_word     = filt_val_next;
        out_next.filter_write    = filt_wr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            board_reg     <= 1'b0;
            last_seq_reg  <= '1;
            atten_reg     <= '0;
            atten_s0_reg  <= '0;
            atten_s1_reg  <= '0;
            dither_reg    <= 1'b0;
            random_reg    <= 1'b0;
            receivers_reg <= RX_COUNT_RST;
            rate_reg      <= '0;
            rx1_reg       <= RX1_FREQ_RST;
            rx2_reg       <= RX2_FREQ_RST;
            tx_reg        <= TX_FREQ_RST;
            drive_reg     <= '0;
            filt_val_reg  <= '0;
            filt_sent_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                board_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                last_seq_reg  <= last_seq_next;
                atten_reg     <= atten_next;
                atten_s0_reg  <= atten_s0_next;
                atten_s1_reg  <= atten_s1_next;
                dither_reg    <= dither_next;
                random_reg    <= random_next;
                receivers_reg <= receivers_next;
                rate_reg      <= rate_next;
                rx1_reg       <= rx1_next;
                rx2_reg       <= rx2_next;
                tx_reg        <= tx_next;
                drive_reg     <= drive_next;
                filt_val_reg  <= filt_val_next;
                filt_sent_reg <= filt_sent_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the SDR control frame decoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scfd_pkg::*;

    localparam logic [7:0] CMD_ADDR_MASK = 8'hFE;
    localparam int         PHASE_HEADERS = 400;
    localparam int         HOLD_CYCLES   = 300;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    scfd_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    scfd_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    sdr_control_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // decoder state as predicted
    logic [31:0] prev_seq;
    logic        tx_mox;
    logic [4:0]  att_now, att_s0, att_s1, att_s0_seen, att_s1_seen;
    logic        dith, rnd;
    logic [3:0]  n_rx;
    logic [1:0]  rate;
    logic [31:0] f_rx1, f_rx2, f_tx;
    logic [7:0]  drv;
    logic [15:0] filt_cur, filt_sent;
    logic        board_present;

    scfd_in_t    header_backlog[$];
    scfd_out_t   settings_due[$];
    logic [31:0] seq_next = 32'd0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_req       = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    bit  s_took         = 1'b0;

    int  err_count      = 0;
    int  n_accepted     = 0;
    int  n_checked      = 0;
    int  n_filter_wr    = 0;
    int  n_seq_breaks   = 0;
    int  n_board_writes = 0;

    task automatic reset_model();
        prev_seq      = 32'hFFFF_FFFF;
        tx_mox        = 1'b0;
        att_now       = '0;
        att_s0        = '0;
        att_s1        = '0;
        att_s0_seen   = '0;
        att_s1_seen   = '0;
        dith          = 1'b0;
        rnd           = 1'b0;
        n_rx          = 4'd2;
        rate          = '0;
        f_rx1         = 32'd4706000;
        f_rx2         = 32'd1008000;
        f_tx          = 32'd3630000;
        drv           = '0;
        filt_cur      = '0;
        filt_sent     = '0;
        board_present = 1'b0;
    endtask

    // signed band thresholds on the rx1 frequency
    function automatic logic [15:0] band_filter(input logic [31:0] f);
        int         sf;
        logic [7:0] hp, lp;
        sf = f;
        if (sf < 1416000)       hp = HP_1K5;
        else if (sf < 6500000)  hp = HP_6M5;
        else if (sf < 9500000)  hp = HP_9M5;
        else if (sf < 13000000) hp = HP_13M;
        else if (sf < 20000000) hp = HP_20M;
        else                    hp = HP_BYP;
        if (sf > 32000000)      lp = LP_6M;
        else if (sf > 22000000) lp = LP_10M;
        else if (sf > 15000000) lp = LP_17M;
        else if (sf > 8000000)  lp = LP_30M;
        else if (sf > 4500000)  lp = LP_60M;
        else if (sf > 2400000)  lp = LP_80M;
        else                    lp = LP_160M;
        return {hp, lp};
    endfunction

    function automatic scfd_out_t decode_header(input scfd_in_t h);
        scfd_out_t  r;
        logic [7:0] a0, a1;
        a0 = h.slot0_c0 & CMD_ADDR_MASK;
        a1 = h.slot1_c0 & CMD_ADDR_MASK;
        r  = '0;

        r.seq_error = (h.seq_number != prev_seq + 32'd1);
        prev_seq    = h.seq_number;
        tx_mox      = h.slot0_c0[0];

        if (a0 == ADDR_ATTEN) begin
            att_now = h.slot0_c4[4:0];
            att_s0  = att_now;
        end
        if (a1 == ADDR_ATTEN) begin
            att_now = h.slot1_c4[4:0];
            att_s1  = att_now;
        end
        if (a0 == ADDR_GENERAL) begin
            n_rx = {1'b0, h.slot0_c4[5:3]} + 4'd1;
            rate = h.slot0_c1[1:0];
            dith = h.slot0_c3[3];
            rnd  = h.slot0_c3[4];
        end
        if (a1 == ADDR_GENERAL) begin
            dith = h.slot1_c3[3];
            rnd  = h.slot1_c3[4];
        end
        // a slot latch that moved overrides the attenuator, slot 1 last
        if (att_s0_seen != att_s0) begin
            att_now     = att_s0;
            att_s0_seen = att_s0;
        end
        if (att_s1_seen != att_s1) begin
            att_now     = att_s1;
            att_s1_seen = att_s1;
        end
        if (a1 == ADDR_GENERAL) n_rx = {1'b0, h.slot1_c4[5:3]} + 4'd1;

        if (a0 == ADDR_TXFREQ)  f_tx  = {h.slot0_c1, h.slot0_c2, h.slot0_c3, h.slot0_c4};
        if (a1 == ADDR_TXFREQ)  f_tx  = {h.slot1_c1, h.slot1_c2, h.slot1_c3, h.slot1_c4};
        if (a0 == ADDR_RX1FREQ) f_rx1 = {h.slot0_c1, h.slot0_c2, h.slot0_c3, h.slot0_c4};
        if (a1 == ADDR_RX1FREQ) f_rx1 = {h.slot1_c1, h.slot1_c2, h.slot1_c3, h.slot1_c4};
        if (a0 == ADDR_RX2FREQ) f_rx2 = {h.slot0_c1, h.slot0_c2, h.slot0_c3, h.slot0_c4};
        if (a1 == ADDR_RX2FREQ) f_rx2 = {h.slot1_c1, h.slot1_c2, h.slot1_c3, h.slot1_c4};

        if (a1 == ADDR_DRIVE) drv = h.slot1_c1;

        if (board_present && a1 == ADDR_DRIVE) begin
            if (h.slot1_c2[6]) filt_cur = {h.slot1_c3 & MANUAL_HP_MASK, h.slot1_c4};
            else               filt_cur = band_filter(f_rx1);
        end
        if (board_present && filt_sent != filt_cur) begin
            filt_sent      = filt_cur;
            r.filter_write = 1'b1;
            n_filter_wr++;
        end
        if (r.seq_error) n_seq_breaks++;

        r.transmit_on     = tx_mox;
        r.rate_code       = rate;
        r.rx_count        = n_rx;
        r.rx_control_code = {rnd, dith, att_now};
        r.rx1_freq        = f_rx1;
        r.rx2_freq        = f_rx2;
        r.tx_freq         = f_tx;
        r.tx_drive        = drv;
        r.filter_word     = filt_cur;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch at result %0d: %s", $time, n_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_settings(input scfd_out_t got, input scfd_out_t want);
        check_field("seq_error", 32'(got.seq_error), 32'(want.seq_error));
        check_field("transmit_on", 32'(got.transmit_on), 32'(want.transmit_on));
        check_field("rate_code", 32'(got.rate_code), 32'(want.rate_code));
        check_field("rx_count", 32'(got.rx_count), 32'(want.rx_count));
        check_field("rx_control_code", 32'(got.rx_control_code), 32'(want.rx_control_code));
        check_field("rx1_freq", got.rx1_freq, want.rx1_freq);
        check_field("rx2_freq", got.rx2_freq, want.rx2_freq);
        check_field("tx_freq", got.tx_freq, want.tx_freq);
        check_field("tx_drive", 32'(got.tx_drive), 32'(want.tx_drive));
        check_field("filter_word", 32'(got.filter_word), 32'(want.filter_word));
        check_field("filter_write", 32'(got.filter_write), 32'(want.filter_write));
    endtask

    // monitor: sample every handshake at the rising edge
    always @(posedge aclk) begin
        s_took = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                board_present = cfg_data;
                n_board_writes++;
            end
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                n_accepted++;
                settings_due.push_back(decode_header(s_data));
            end
            if (m_valid && m_ready) begin
                n_checked++;
                if (settings_due.size() == 0) report_mismatch("result with nothing outstanding");
                else check_settings(m_data, settings_due.pop_front());
            end
        end
    end

    // header driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (header_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= header_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_served != hold_req) begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_header(input logic [7:0] s0c0, input logic [31:0] s0w,
                               input logic [7:0] s1c0, input logic [31:0] s1w);
        scfd_in_t h;
        h.seq_number = seq_next;
        {h.slot0_c0, h.slot0_c1, h.slot0_c2, h.slot0_c3, h.slot0_c4} = {s0c0, s0w};
        {h.slot1_c0, h.slot1_c1, h.slot1_c2, h.slot1_c3, h.slot1_c4} = {s1c0, s1w};
        seq_next = seq_next + 32'd1;
        header_backlog.push_back(h);
    endtask

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(7))
            0:       return ADDR_GENERAL;
            1:       return ADDR_TXFREQ;
            2:       return ADDR_RX1FREQ;
            3:       return ADDR_RX2FREQ;
            4:       return ADDR_DRIVE;
            5:       return ADDR_ATTEN;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_word(input logic [7:0] addr);
        // frequency commands mostly carry in-band values
        if ((addr == ADDR_TXFREQ || addr == ADDR_RX1FREQ || addr == ADDR_RX2FREQ)
            && $urandom_range(99) < 70)
            return $urandom_range(0, 40000000);
        return $urandom;
    endfunction

    task automatic push_random();
        logic [7:0] a0, a1;
        a0 = pick_addr() | 8'($urandom_range(1));
        a1 = pick_addr() | 8'($urandom_range(1));
        if ($urandom_range(99) < 8) seq_next = $urandom;
        push_header(a0, pick_word(a0 & CMD_ADDR_MASK), a1, pick_word(a1 & CMD_ADDR_MASK));
    endtask

    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (header_backlog.size() != 0 || s_valid || settings_due.size() != 0);
    endtask

    task automatic set_board(input logic present);
        wait_drained();
        // decoder latency before touching the register
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= present;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        #1;
    endtask

    task automatic run_phase(input logic present, input int send_idle, input int recv_stall,
                             input bit squeeze);
        set_board(present);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        if (squeeze) hold_req++;
        repeat (PHASE_HEADERS) push_random();
        wait_drained();
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // board absent: general, frequency, attenuator and drive commands
        push_header(ADDR_GENERAL, 32'h03FF_1838, ADDR_ATTEN, 32'h0000_00FF);
        push_header(ADDR_GENERAL | 8'h01, 32'h0000_0000, ADDR_GENERAL | 8'h01, 32'hFFFF_0738);
        push_header(ADDR_TXFREQ, 32'hFFFF_FFFF, ADDR_RX1FREQ, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'h1234_5678, ADDR_RX1FREQ | 8'h01, 32'h8000_0000);
        push_header(ADDR_RX2FREQ, 32'h0000_0000, ADDR_TXFREQ, 32'h00A5_A5A5);
        push_header(ADDR_ATTEN, 32'h0000_000A, ADDR_ATTEN, 32'h0000_0015);
        push_header(ADDR_ATTEN, 32'h0000_000A, ADDR_DRIVE, 32'hFF40_FFFF);
        // sequence break, then wrap through all ones
        seq_next = 32'hFFFF_FFFE;
        push_header(8'hFF, 32'hFFFF_FFFF, 8'hFE, 32'hFFFF_FFFF);
        push_header(8'hFE, 32'h0000_0000, 8'hFF, 32'h0000_0000);
        push_header(8'hFE, 32'h0000_0000, 8'hFE, 32'h0000_0000);

        // board present: manual word, repeat without change, then band edges
        set_board(1'b1);
        push_header(8'hFE, 32'h0, ADDR_DRIVE, 32'h0040_FFFF);
        push_header(8'hFE, 32'h0, ADDR_DRIVE, 32'h0040_FFFF);
        push_header(ADDR_RX1FREQ, 32'hFFFF_FFFF, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd1415999, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd1416000, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd6500000, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd9499999, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd13000000, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd20000000, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd32000001, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'h7FFF_FFFF, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd2400001, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd8000001, ADDR_DRIVE, 32'h0000_0000);
        push_header(ADDR_RX1FREQ, 32'd15000001, ADDR_DRIVE, 32'h0000_0000);
        wait_drained();

        run_phase(1'b1, 0, 0, 1'b0);
        run_phase(1'b0, 68, 0, 1'b0);
        run_phase(1'b1, 0, 68, 1'b0);
        run_phase(1'b0, 8, 8, 1'b0);
        run_phase(1'b1, 0, 0, 1'b1);

        repeat (20) @(posedge aclk);
        if (settings_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", settings_due.size()));
        $display("Covered %0d headers and %0d settings records over %0d filter board writes,",
                 n_accepted, n_checked, n_board_writes);
        $display("with %0d filter word writes and %0d sequence breaks predicted.",
                 n_filter_wr, n_seq_breaks);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", settings_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
